[rtl/core/imu_frame_deframer_tlv_core_assert.svh]
// Assertion macros for the deframer core
`ifndef IMU_FRAME_DEFRAMER_TLV_CORE_ASSERT_SVH
`define IMU_FRAME_DEFRAMER_TLV_CORE_ASSERT_SVH
// implication checked every clock, ignored during reset
`define IFD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// property that must hold on every clock out of reset
`define IFD_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`endif

[rtl/core/ifd_pkg.sv]
// ----------------------------------------------------------------------------
// ifd_pkg
// Shared types and constants for the sync/length TLV deframer.
// ----------------------------------------------------------------------------
package ifd_pkg;
  localparam int MaxRecordBytes = 20;
  localparam int NumKinds       = 10;
  localparam int RecCntW        = 8;

  // front to back command queue
  localparam int CmdQDepth = 4;
  localparam int CmdQAw    = $clog2(CmdQDepth);
  localparam logic [CmdQAw:0] CmdQFull = (CmdQAw + 1)'(CmdQDepth);

  localparam logic [7:0] Sync1 = 8'h59;
  localparam logic [7:0] Sync2 = 8'h53;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StCkFail   = 2'd1;
  localparam logic [1:0] StTrunc    = 2'd2;
  localparam logic [1:0] StMismatch = 2'd3;

  localparam logic [3:0] KindSummary = 4'd0;

  typedef logic [NumKinds-1:0] kind_mask_t;

  // result item
  typedef struct packed {
    logic [3:0]  record_kind;
    logic [1:0]  frame_status;
    logic [15:0] transaction_id;
    logic [63:0] payload_lo;
    logic [63:0] payload_mid;
    logic [31:0] payload_hi;
    logic        last_of_frame;
  } ifd_result_t;

  // front to back: one finished frame, or one record write
  typedef struct packed {
    logic        is_frame;      // 1 frame end, 0 record store write
    logic        good;
    logic [1:0]  status;
    logic [15:0] tid;
    kind_mask_t  present;
    logic [3:0]  kidx;          // kind index for a store write
    logic [159:0] value;
  } ifd_cmd_t;

  function automatic logic [7:0] kind_id(input int k);
    logic [7:0] r;
    case (k)
      0: r = 8'h01;
      1: r = 8'h10;
      2: r = 8'h20;
      3: r = 8'h40;
      4: r = 8'h41;
      5: r = 8'h50;
      6: r = 8'h51;
      7: r = 8'h52;
      8: r = 8'h68;
      default: r = 8'h70;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] kind_size(input int k);
    logic [7:0] r;
    case (k) inside
      0: r = 8'd2;
      1, 2, 3: r = 8'd12;
      4: r = 8'd16;
      5: r = 8'd11;
      6, 7: r = 8'd4;
      8: r = 8'd20;
      default: r = 8'd12;
    endcase
    return r;
  endfunction
endpackage

[rtl/core/ifd_if.sv]
// ----------------------------------------------------------------------------
// ifd_byte_if / ifd_result_if
// Valid/ready channels for the received bytes and the result items.
// ----------------------------------------------------------------------------
interface ifd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ifd_result_if;
  logic        valid;
  logic        ready;
  logic [3:0]  record_kind;
  logic [1:0]  frame_status;
  logic [15:0] transaction_id;
  logic [63:0] payload_lo;
  logic [63:0] payload_mid;
  logic [31:0] payload_hi;
  logic        last_of_frame;
  modport source (output valid, output record_kind, output frame_status,
                  output transaction_id, output payload_lo, output payload_mid,
                  output payload_hi, output last_of_frame, input ready);
  modport sink   (input valid, input record_kind, input frame_status,
                  input transaction_id, input payload_lo, input payload_mid,
                  input payload_hi, input last_of_frame, output ready);
endinterface

[rtl/core/ifd_front.sv]
// ----------------------------------------------------------------------------
// ifd_front
// Byte parser: sync hunt, header, checksum and record framing.
// ----------------------------------------------------------------------------
module ifd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_valid,
  input  logic [7:0]        byte_data,
  output logic              byte_ready,
  output logic              cmd_valid,
  output ifd_pkg::ifd_cmd_t cmd,
  input  logic              cmd_ready
);
  import ifd_pkg::*;

  typedef enum logic [3:0] {
    PH_HUNT1, PH_HUNT2, PH_TIDLO, PH_TIDHI, PH_LEN,
    PH_RID, PH_RLEN, PH_RVAL, PH_CK1, PH_CK2
  } phase_t;

  phase_t       phase_r;
  logic [15:0]  tid_r;
  logic [7:0]   flen_r, pcnt_r, suma_r, sumb_r, ck1_r, rid_r, rlen_r;
  logic [RecCntW-1:0] rcnt_r;
  logic [159:0] stage_r;
  kind_mask_t   present_r;
  logic [1:0]   status_r;
  logic         cmd_valid_r;
  ifd_cmd_t     cmd_r;

  // a byte may need to post a command; hold it off while one is pending
  assign byte_ready = !cmd_valid_r || cmd_ready;
  assign cmd_valid  = cmd_valid_r;
  assign cmd        = cmd_r;

  logic [7:0] b, sa_n, sb_n, pcnt_n, rcnt_n;
  logic       rec_end, hit, size_ok, acc, rec_wr, cmd_fire;
  logic [3:0] hidx;
  logic [159:0] stage_n;
  phase_t     pl_ph_n;   // payload phase after this byte
  logic [1:0] pl_st_n;

  always_comb begin
    b      = byte_data;
    acc    = byte_valid && byte_ready;
    sa_n   = suma_r + b;
    sb_n   = sumb_r + sa_n;
    pcnt_n = pcnt_r + 8'd1;
    rcnt_n = rcnt_r + 8'd1;
    stage_n = stage_r;
    if (rcnt_r < 8'(MaxRecordBytes))
      stage_n[{rcnt_r[4:0], 3'b000} +: 8] = b;
    // record end when value complete or zero-length header
    rec_end = (phase_r == PH_RLEN && b == 8'd0) ||
              (phase_r == PH_RVAL && rcnt_n == rlen_r);
    hit  = 1'b0;
    hidx = '0;
    for (int k = 0; k < NumKinds; k++) begin
      if (kind_id(k) == rid_r && !hit) begin
        hit  = 1'b1;
        hidx = 4'(k);
      end
    end
    size_ok = (phase_r == PH_RLEN) ? (kind_size(int'(hidx)) == 8'd0)
                                   : (kind_size(int'(hidx)) == rlen_r);
    pl_ph_n = phase_r;
    pl_st_n = status_r;
    if (phase_r == PH_RID) pl_ph_n = PH_RLEN;
    else if (phase_r == PH_RLEN) pl_ph_n = (b == 8'd0) ? PH_RID : PH_RVAL;
    else if (rec_end) pl_ph_n = PH_RID;
    rec_wr = 1'b0;
    if (rec_end && hit) begin
      if (!size_ok) pl_st_n = StMismatch;
      else rec_wr = 1'b1;
    end
    if (pcnt_n == flen_r) begin
      if (pl_ph_n != PH_RID) pl_st_n = StTrunc;
      pl_ph_n = PH_CK1;
    end
    cmd_fire = acc && (rec_wr || phase_r == PH_CK2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT1;
      cmd_valid_r <= 1'b0;
      tid_r <= '0; flen_r <= '0; pcnt_r <= '0; suma_r <= '0; sumb_r <= '0;
      ck1_r <= '0; rid_r <= '0; rlen_r <= '0; rcnt_r <= '0; stage_r <= '0;
      present_r <= '0; status_r <= StOk;
    end else begin
      cmd_valid_r <= cmd_fire || (cmd_valid_r && !cmd_ready);
      if (acc) begin
        unique case (phase_r) inside
          PH_HUNT1: if (b == Sync1) phase_r <= PH_HUNT2;
          PH_HUNT2: begin
            if (b == Sync2) begin
              suma_r <= '0; sumb_r <= '0; present_r <= '0; status_r <= StOk;
              phase_r <= PH_TIDLO;
            end else if (b != Sync1) phase_r <= PH_HUNT1;
          end
          PH_TIDLO: begin
            tid_r <= {8'd0, b}; suma_r <= sa_n; sumb_r <= sb_n;
            phase_r <= PH_TIDHI;
          end
          PH_TIDHI: begin
            tid_r[15:8] <= b; suma_r <= sa_n; sumb_r <= sb_n;
            phase_r <= PH_LEN;
          end
          PH_LEN: begin
            flen_r <= b; pcnt_r <= '0; suma_r <= sa_n; sumb_r <= sb_n;
            phase_r <= (b == 8'd0) ? PH_CK1 : PH_RID;
          end
          PH_RID, PH_RLEN, PH_RVAL: begin
            suma_r <= sa_n; sumb_r <= sb_n; pcnt_r <= pcnt_n;
            if (phase_r == PH_RID) begin
              rid_r <= b; rcnt_r <= '0; stage_r <= '0;
            end else if (phase_r == PH_RLEN) begin
              rlen_r <= b;
            end else begin
              stage_r <= stage_n; rcnt_r <= rcnt_n;
            end
            if (rec_wr) begin
              present_r[hidx] <= 1'b1;
              cmd_r.is_frame  <= 1'b0;
              cmd_r.kidx      <= hidx;
              cmd_r.value     <= (phase_r == PH_RVAL) ? stage_n : 160'd0;
            end
            status_r <= pl_st_n;
            phase_r  <= pl_ph_n;
          end
          PH_CK1: begin ck1_r <= b; phase_r <= PH_CK2; end
          PH_CK2: begin
            cmd_r.is_frame <= 1'b1;
            cmd_r.good     <= (ck1_r == suma_r) && (b == sumb_r);
            cmd_r.status   <= ((ck1_r == suma_r) && (b == sumb_r)) ? status_r : StCkFail;
            cmd_r.tid      <= tid_r;
            cmd_r.present  <= present_r;
            phase_r        <= PH_HUNT1;
          end
          default: phase_r <= PH_HUNT1;
        endcase
      end
    end
  end
endmodule

[rtl/core/ifd_back.sv]
// ----------------------------------------------------------------------------
// ifd_back
// Command queue, shadow store and frame-end result emitter.
// ----------------------------------------------------------------------------
module ifd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  ifd_pkg::ifd_cmd_t cmd,
  output logic              cmd_ready,
  output logic              res_valid,
  output ifd_pkg::ifd_result_t res,
  input  logic              res_ready
);
  import ifd_pkg::*;

  ifd_cmd_t   q_r [CmdQDepth];
  logic [CmdQAw-1:0] wp_r, rp_r;
  logic [CmdQAw:0]   cnt_r;

  typedef enum logic [1:0] {B_IDLE, B_EMIT, B_SUM} bstate_t;
  bstate_t    st_r;
  ifd_cmd_t   cur_r;
  logic [3:0] k_r;
  logic       rd_pend_r;
  logic [159:0] mem_r [NumKinds];
  logic [159:0] rd_r;
  logic       res_valid_r;
  ifd_result_t res_r;

  assign cmd_ready = cnt_r != CmdQFull;
  assign res_valid = res_valid_r;
  assign res       = res_r;

  logic push, pop, oslot, res_fire;
  ifd_cmd_t head;
  assign head  = q_r[rp_r];
  assign oslot = !res_valid_r || res_ready;
  // the queue drains only while the emitter is idle, so store writes of the
  // next frame never overtake a frame still being read out
  assign pop   = cnt_r != '0 && st_r == B_IDLE;
  assign push  = cmd_valid && cmd_ready;

  // next present kind at or after k_r
  logic       nfound;
  logic [3:0] nidx;
  always_comb begin
    nfound = 1'b0;
    nidx   = '0;
    for (int k = 0; k < NumKinds; k++) begin
      if (!nfound && 4'(k) >= k_r && cur_r.present[k]) begin
        nfound = 1'b1;
        nidx   = 4'(k);
      end
    end
  end

  assign res_fire = oslot && ((st_r == B_SUM) ||
                              (st_r == B_EMIT && nfound && rd_pend_r));

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= cmd;
    if (pop && !head.is_frame) mem_r[head.kidx] <= head.value;
    rd_r <= mem_r[nidx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
      st_r <= B_IDLE; res_valid_r <= 1'b0; k_r <= '0; rd_pend_r <= 1'b0;
    end else begin
      if (push) wp_r <= wp_r + CmdQAw'(1);
      if (pop)  rp_r <= rp_r + CmdQAw'(1);
      cnt_r <= cnt_r + (CmdQAw + 1)'(push) - (CmdQAw + 1)'(pop);
      res_valid_r <= res_fire || (res_valid_r && !res_ready);
      unique case (st_r)
        B_IDLE: if (pop && head.is_frame) begin
          cur_r <= head; k_r <= '0; rd_pend_r <= 1'b0;
          st_r  <= head.good ? B_EMIT : B_SUM;
        end
        B_EMIT: begin
          if (!nfound) st_r <= B_SUM;
          else if (!rd_pend_r) rd_pend_r <= 1'b1;  // store read in flight
          else if (oslot) begin
            res_r <= '{record_kind: nidx + 4'd1, frame_status: cur_r.status,
                       transaction_id: cur_r.tid, payload_lo: rd_r[63:0],
                       payload_mid: rd_r[127:64], payload_hi: rd_r[159:128],
                       last_of_frame: 1'b0};
            k_r <= nidx + 4'd1;
            rd_pend_r <= 1'b0;
          end
        end
        B_SUM: if (oslot) begin
          res_r <= '{record_kind: KindSummary, frame_status: cur_r.status,
                     transaction_id: cur_r.tid, payload_lo: 64'd0,
                     payload_mid: 64'd0, payload_hi: 32'd0, last_of_frame: 1'b1};
          st_r <= B_IDLE;
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end
endmodule

[rtl/core/imu_frame_deframer_tlv_core.sv]
// ----------------------------------------------------------------------------
// imu_frame_deframer_tlv_core
// Sync/length framed TLV deframer with Fletcher-style check.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle unless the front's single command
// register holds a request the back end has not yet taken. The front parser
// hunts 0x59 0x53, reads id, length and payload records and checks the two
// trailing sums; each good record request goes through a four-entry queue
// and is written into the shadow store by the back end. After the second
// check byte a good frame yields one result per kind present (kind order),
// then a summary with last_of_frame set; a bad frame yields the summary only.
// The queue drains only while the emitter is idle. Once a frame-end request
// leaves the queue, the back end takes the request, does a registered store
// read before each record result, closes the scan and presents the summary;
// a bad frame goes straight to the summary. Input stalls while that burst
// runs and the queue plus command register fill with the next frame's
// record requests, or while the output is backpressured.
module imu_frame_deframer_tlv_core (
  input logic clk,
  input logic rst_n,
  ifd_byte_if.sink     in_ch,
  ifd_result_if.source out_ch
);
  import ifd_pkg::*;
  `include "imu_frame_deframer_tlv_core_assert.svh"

  logic        cmd_valid, cmd_ready;
  ifd_cmd_t    cmd;
  ifd_result_t res;

  ifd_front u_front (
    .clk, .rst_n,
    .byte_valid(in_ch.valid), .byte_data(in_ch.rx_byte), .byte_ready(in_ch.ready),
    .cmd_valid, .cmd, .cmd_ready
  );

  ifd_back u_back (
    .clk, .rst_n, .cmd_valid, .cmd, .cmd_ready,
    .res_valid(out_ch.valid), .res, .res_ready(out_ch.ready)
  );

  assign out_ch.record_kind    = res.record_kind;
  assign out_ch.frame_status   = res.frame_status;
  assign out_ch.transaction_id = res.transaction_id;
  assign out_ch.payload_lo     = res.payload_lo;
  assign out_ch.payload_mid    = res.payload_mid;
  assign out_ch.payload_hi     = res.payload_hi;
  assign out_ch.last_of_frame  = res.last_of_frame;

  // summary always marks the end of a frame, and vice versa
  `IFD_ASSERT_ALWAYS(a_last_kind,
    !out_ch.valid || ((out_ch.record_kind == KindSummary) == out_ch.last_of_frame))
  // a checksum fail never comes with a record result
  `IFD_ASSERT_IMPL(a_ckfail_sum,
    out_ch.valid && out_ch.frame_status == StCkFail, out_ch.last_of_frame)
  // a pending command never lets a new byte in without being taken
  `IFD_ASSERT_IMPL(a_cmd_hold, cmd_valid && !cmd_ready, !in_ch.ready)
endmodule
